/* rtl/biq_pkg.sv */
// ----------------------------------------------------------------------------
// biq_pkg
// Shared widths, coefficient register codes and types for the biquad filter.
// ----------------------------------------------------------------------------
package biq_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 24;
  localparam int COEF_FRAC = 22;
  localparam int CFG_IDX_W = 3;

  // Five products, each at most 2^(COEF_W+SAMPLE_W-2) in magnitude, plus rounding
  localparam int PROD_W = COEF_W + SAMPLE_W;
  localparam int ACC_W  = PROD_W + 3;
  localparam int QUOT_W = ACC_W - COEF_FRAC;

  localparam logic signed [COEF_W-1:0] B0_RESET = COEF_W'(1 << COEF_FRAC);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0,
    REG_B1,
    REG_B2,
    REG_A1,
    REG_A2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coefs_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clipped;
  } result_t;

endpackage

/* rtl/biq_coef_regs.sv */
// ----------------------------------------------------------------------------
// biq_coef_regs
// Coefficient register file written through the configuration channel.
// ----------------------------------------------------------------------------
module biq_coef_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [biq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [biq_pkg::COEF_W-1:0]    cfg_data,
  output biq_pkg::coefs_t               coefs
);
  import biq_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs.b0 <= B0_RESET;
      coefs.b1 <= '0;
      coefs.b2 <= '0;
      coefs.a1 <= '0;
      coefs.a2 <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_B0:  coefs.b0 <= cfg_data;
        REG_B1:  coefs.b1 <= cfg_data;
        REG_B2:  coefs.b2 <= cfg_data;
        REG_A1:  coefs.a1 <= cfg_data;
        REG_A2:  coefs.a2 <= cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

endmodule

/* rtl/biq_core.sv */
// ----------------------------------------------------------------------------
// biq_core
// Sample history and the combinational multiply, sum, round and clip datapath.
// ----------------------------------------------------------------------------
module biq_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               advance,
  input  logic signed [biq_pkg::SAMPLE_W-1:0] x,
  input  biq_pkg::coefs_t                    coefs,
  output biq_pkg::result_t                   result
);
  import biq_pkg::*;

  localparam logic signed [ACC_W-1:0]  ROUND_HALF = ACC_W'(64'sd1 << (COEF_FRAC - 1));
  localparam logic signed [QUOT_W-1:0] Q_MAX = QUOT_W'((64'sd1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [QUOT_W-1:0] Q_MIN = QUOT_W'(-(64'sd1 << (SAMPLE_W - 1)));
  localparam logic signed [SAMPLE_W-1:0] S_MAX = SAMPLE_W'((64'sd1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [SAMPLE_W-1:0] S_MIN = SAMPLE_W'(-(64'sd1 << (SAMPLE_W - 1)));

  logic signed [SAMPLE_W-1:0] x1, x2, y1, y2;
  logic signed [PROD_W-1:0]   p_b0, p_b1, p_b2, p_a1, p_a2;
  logic signed [ACC_W-1:0]    acc;
  logic signed [QUOT_W-1:0]   quot;

  always_comb begin
    p_b0 = coefs.b0 * x;
    p_b1 = coefs.b1 * x1;
    p_b2 = coefs.b2 * x2;
    p_a1 = coefs.a1 * y1;
    p_a2 = coefs.a2 * y2;
    acc  = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
         - ACC_W'(p_a1) - ACC_W'(p_a2) + ROUND_HALF;
    // floor division by 2^COEF_FRAC
    quot = $signed(acc[ACC_W-1:COEF_FRAC]);
    if (quot > Q_MAX) begin
      result.sample  = S_MAX;
      result.clipped = 1'b1;
    end else if (quot < Q_MIN) begin
      result.sample  = S_MIN;
      result.clipped = 1'b1;
    end else begin
      result.sample  = quot[SAMPLE_W-1:0];
      result.clipped = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x1 <= '0;
      x2 <= '0;
      y1 <= '0;
      y2 <= '0;
    end else if (advance) begin
      x2 <= x1;
      x1 <= x;
      y2 <= y1;
      y1 <= result.sample;
    end
  end

endmodule

/* rtl/biq_out_buf.sv */
// ----------------------------------------------------------------------------
// biq_out_buf
// Two-entry output skid buffer: result register plus one spare slot.
// ----------------------------------------------------------------------------
module biq_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  biq_pkg::result_t load_data,
  output logic             has_room,
  output logic             out_valid,
  input  logic             out_ready,
  output biq_pkg::result_t out_data
);
  import biq_pkg::*;

  logic    skid_valid;
  result_t skid_data;
  logic    out_free;

  assign has_room = !skid_valid;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_free) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= load;
        end
      end else if (load) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (load) begin
        out_data <= load_data;
      end
    end else if (load) begin
      skid_data <= load_data;
    end
  end

endmodule

/* rtl/biquad_iir_df1_filter.sv */
// ----------------------------------------------------------------------------
// biquad_iir_df1_filter
// Direct form 1 biquad IIR filter with programmable Q1.22 coefficients.
// ----------------------------------------------------------------------------
// Usage:
//   Input samples arrive on the s_* stream, filtered samples leave on m_*.
//   Each request is accepted when tvalid and tready are both high.
//   A sample lands in an input register, then one pass through five
//   multipliers, the adder, rounding and clipping writes the result
//   register and the history; the result shows on m_* from the result
//   register. One sample per cycle is sustained while the receiver does
//   not stall, as the previous output feeds back through that pass.
//   When the receiver stalls, a spare slot behind the result register
//   still takes one more result, so s_tready stays high until both the
//   input register and the spare slot are full.
//   Coefficients are written over cfg_* (index 0..4: b0, b1, b2, a1, a2);
//   writes beyond that range are dropped. Write them only while idle.
//   Reset (rst, synchronous) clears the sample history, empties all
//   stages and sets b0 to 1.0 and the other coefficients to zero.
// ----------------------------------------------------------------------------
module biquad_iir_df1_filter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [biq_pkg::SAMPLE_W-1:0]  s_tdata,   // [15:0] sample_in
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [biq_pkg::SAMPLE_W-1:0]  m_tdata,   // [15:0] sample_out
  output logic                          m_tuser,   // [0] clipped
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [biq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [biq_pkg::COEF_W-1:0]    cfg_data
);
  import biq_pkg::*;

  logic                       x_valid;
  logic signed [SAMPLE_W-1:0] x;
  logic                       advance;
  logic                       has_room;
  coefs_t                     coefs;
  result_t                    result;
  result_t                    out_data;

  assign cfg_ready = 1'b1;
  assign advance   = x_valid && has_room;
  assign s_tready  = !x_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_valid <= 1'b0;
    end else if (s_tready) begin
      x_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      x <= s_tdata;
    end
  end

  biq_coef_regs u_coef_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coefs     (coefs)
  );

  biq_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .x       (x),
    .coefs   (coefs),
    .result  (result)
  );

  biq_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .load_data (result),
    .has_room  (has_room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data)
  );

  assign m_tdata = out_data.sample;
  assign m_tuser = out_data.clipped;

endmodule

/* rtl/biq_checker.sv */
// ----------------------------------------------------------------------------
// biq_checker
// Port-level checks for the biquad filter, bound to the top level.
// ----------------------------------------------------------------------------
module biq_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [biq_pkg::SAMPLE_W-1:0]  m_tdata,
  input logic                          m_tuser
);
  import biq_pkg::*;

  localparam logic [SAMPLE_W-1:0] LIM_MAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] LIM_MIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};

  // Nothing is left in flight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // A clipped result sits exactly at one of the limits
  a_clip_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata == LIM_MAX || m_tdata == LIM_MIN))
    else $error("clipped result not at a limit");

  // A request taken with the output empty reaches the output through the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |-> ##2 m_tvalid)
    else $error("no result after accepted request");

endmodule

bind biquad_iir_df1_filter biq_checker u_biq_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for biquad_iir_df1_filter. Samples are pushed through
// the input stream while a bit-exact model of the direct form 1 datapath
// (full-precision sum, round half up, saturation, history update) predicts
// every filtered sample. Directed cases cover passthrough, both saturation
// limits, exact limits, rounding ties, all five taps and unused register
// indexes. Random phases follow under several coefficient sets and
// different stall patterns on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import biq_pkg::*;

  localparam int     NUM_COEFS   = int'(REG_A2) + 1;
  localparam int     QUIET_LIMIT = 3000;
  localparam int     MAX_REPORTS = 100;
  localparam longint SAT_MAX     = (longint'(1) << (SAMPLE_W - 1)) - 1;
  localparam longint SAT_MIN     = -SAT_MAX - 1;
  localparam logic [COEF_W-1:0] COEF_MAX  = {1'b0, {(COEF_W - 1){1'b1}}};
  localparam logic [COEF_W-1:0] COEF_MIN  = {1'b1, {(COEF_W - 1){1'b0}}};
  localparam logic [COEF_W-1:0] COEF_ONE  = COEF_W'(1 << COEF_FRAC);
  localparam logic [COEF_W-1:0] COEF_HALF = COEF_W'(1 << (COEF_FRAC - 1));

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [SAMPLE_W-1:0]  s_tdata   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [SAMPLE_W-1:0]  m_tdata;
  logic                 m_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0]    cfg_data  = '0;

  biquad_iir_df1_filter dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Filter model state
  logic signed [COEF_W-1:0]   coef_regs [NUM_COEFS];
  logic signed [SAMPLE_W-1:0] x_hist1 = '0;
  logic signed [SAMPLE_W-1:0] x_hist2 = '0;
  logic signed [SAMPLE_W-1:0] y_hist1 = '0;
  logic signed [SAMPLE_W-1:0] y_hist2 = '0;

  result_t pending_results [$];
  int      error_count   = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      quiet_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic result_t filter_step(input logic signed [SAMPLE_W-1:0] x);
    longint  acc;
    longint  y;
    result_t r;
    acc = longint'(coef_regs[REG_B0]) * longint'(x)
        + longint'(coef_regs[REG_B1]) * longint'(x_hist1)
        + longint'(coef_regs[REG_B2]) * longint'(x_hist2)
        - longint'(coef_regs[REG_A1]) * longint'(y_hist1)
        - longint'(coef_regs[REG_A2]) * longint'(y_hist2);
    acc = acc + (longint'(1) <<< (COEF_FRAC - 1));
    y = acc >>> COEF_FRAC;
    r.clipped = 1'b0;
    if (y > SAT_MAX) begin
      y = SAT_MAX;
      r.clipped = 1'b1;
    end else if (y < SAT_MIN) begin
      y = SAT_MIN;
      r.clipped = 1'b1;
    end
    r.sample = SAMPLE_W'(y);
    x_hist2 = x_hist1;
    x_hist1 = x;
    y_hist2 = y_hist1;
    y_hist1 = r.sample;
    return r;
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: begin
        return $urandom_range(0, 1) ? SAMPLE_W'(SAT_MAX) : SAMPLE_W'(SAT_MIN);
      end
      1, 2: begin
        return SAMPLE_W'($urandom_range(0, 512)) - SAMPLE_W'(256);
      end
      default: begin
        return SAMPLE_W'($urandom);
      end
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] extreme_coef();
    case ($urandom_range(0, 3))
      0:       return COEF_MIN;
      1:       return COEF_MAX;
      2:       return '0;
      default: return COEF_W'($urandom);
    endcase
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] x);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= x;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(filter_step(x));
  endtask

  // Hold off until every outstanding sample has come back
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_coef(input logic [CFG_IDX_W-1:0] index,
                            input logic [COEF_W-1:0]    value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (index < NUM_COEFS) coef_regs[index] = value;
  endtask

  task automatic load_coefs(input logic [COEF_W-1:0] b0, input logic [COEF_W-1:0] b1,
                            input logic [COEF_W-1:0] b2, input logic [COEF_W-1:0] a1,
                            input logic [COEF_W-1:0] a2);
    wait_idle();
    write_coef(REG_B0, b0);
    write_coef(REG_B1, b1);
    write_coef(REG_B2, b2);
    write_coef(REG_A1, a1);
    write_coef(REG_A2, a2);
    cfg_valid <= 1'b0;
  endtask

  // Reset coefficients give unity gain, so samples must come back unchanged
  task automatic test_reset_passthrough();
    send_sample('0);
    send_sample(SAMPLE_W'(SAT_MAX));
    send_sample(SAMPLE_W'(SAT_MIN));
    send_sample(SAMPLE_W'(1));
    send_sample('1);
  endtask

  task automatic test_saturation();
    load_coefs(COEF_MAX, '0, '0, '0, '0);
    send_sample(SAMPLE_W'(SAT_MAX));
    send_sample(SAMPLE_W'(SAT_MIN));
    // Gain -2.0: +2^14 lands exactly on the low limit, -2^14 clips high
    load_coefs(COEF_MIN, '0, '0, '0, '0);
    send_sample(SAMPLE_W'(SAT_MIN));
    send_sample(SAMPLE_W'(16384));
    send_sample(-SAMPLE_W'(16384));
  endtask

  // Gain 0.5 puts odd samples exactly on a rounding tie
  task automatic test_rounding();
    load_coefs(COEF_HALF, '0, '0, '0, '0);
    send_sample(SAMPLE_W'(1));
    send_sample('1);
    send_sample(SAMPLE_W'(3));
    send_sample(-SAMPLE_W'(3));
  endtask

  task automatic test_all_taps();
    load_coefs(COEF_HALF, COEF_W'(-1048576), COEF_W'(786432), COEF_W'(-3145728),
               COEF_W'(1677721));
    send_sample(SAMPLE_W'(20000));
    send_sample(SAMPLE_W'(-12000));
    send_sample(SAMPLE_W'(500));
    // Feedback of +2.0 on the last output drives the loop into the rail
    load_coefs(COEF_ONE, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX);
    send_sample(SAMPLE_W'(SAT_MAX));
    send_sample(SAMPLE_W'(SAT_MIN));
    send_sample('0);
  endtask

  // Writes past the last coefficient must leave every coefficient alone
  task automatic test_unused_index();
    load_coefs(COEF_ONE, COEF_HALF, '0, COEF_W'(-2097152), COEF_W'(1048576));
    for (int i = NUM_COEFS; i < (1 << CFG_IDX_W); i++) begin
      write_coef(CFG_IDX_W'(i), COEF_W'($urandom));
    end
    cfg_valid <= 1'b0;
    send_sample(SAMPLE_W'(1000));
    send_sample(SAMPLE_W'(-30000));
    send_sample(SAMPLE_W'(SAT_MAX));
  endtask

  task automatic test_random_phase(input int send_pct, input int recv_pct,
                                   input int n_items);
    int lim;
    int a1;
    int a2;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int set = 0; set < 3; set++) begin
      case (set)
        0: begin
          // Stable poles: a2 up to 0.8, a1 inside the stability triangle
          a2  = $urandom_range(0, 3355443);
          lim = (4194304 + a2) * 9 / 10;
          a1  = int'($urandom_range(0, 2 * lim)) - lim;
          load_coefs(COEF_W'(int'($urandom_range(0, 2097152)) - 1048576),
                     COEF_W'(int'($urandom_range(0, 2097152)) - 1048576),
                     COEF_W'(int'($urandom_range(0, 2097152)) - 1048576),
                     COEF_W'(a1), COEF_W'(a2));
        end
        1: begin
          load_coefs(extreme_coef(), extreme_coef(), extreme_coef(),
                     extreme_coef(), extreme_coef());
        end
        default: begin
          load_coefs(COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom),
                     COEF_W'($urandom), COEF_W'($urandom));
        end
      endcase
      for (int i = 0; i < n_items / 3; i++) send_sample(rand_sample());
    end
  endtask

  // Check each returned sample and set the receiver stall for the next cycle
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: unexpected sample_out=%h clipped=%b", $time, m_tdata, m_tuser);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata !== want.sample || m_tuser !== want.clipped) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: mismatch expected sample_out=%h clipped=%b, got %h %b",
                     $time, want.sample, want.clipped, m_tdata, m_tuser);
        end
      end
    end
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < NUM_COEFS; i++) coef_regs[i] = '0;
    coef_regs[REG_B0] = B0_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 30;
    recv_idle_pct = 60;
    test_reset_passthrough();
    test_saturation();
    test_rounding();
    test_all_taps();
    test_unused_index();
    test_random_phase(30, 60, 360);
    test_random_phase(60, 30, 360);
    test_random_phase(0, 0, 360);
    wait_idle();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      $display("%0t: %0d samples never returned", $time, pending_results.size());
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
